@@ src/wsfe_pkg.sv @@
// ----------------------------------------------------------------------------
// wsfe_pkg
// Types, codes and helpers shared by the masked client frame encoder.
// ----------------------------------------------------------------------------
package wsfe_pkg;

    localparam int unsigned LEN_W       = 63;
    localparam int unsigned KEY_W       = 32;
    localparam int unsigned STEP_W      = 4;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    localparam logic [LEN_W-1:0] LEN_SHORT_MAX = LEN_W'(125);
    localparam logic [LEN_W-1:0] LEN_MID_MAX   = LEN_W'(16'hFFFF);
    localparam logic [6:0]       LEN_CODE_16   = 7'd126;
    localparam logic [6:0]       LEN_CODE_64   = 7'd127;
    localparam logic             MASK_BIT      = 1'b1;

    // Position of the first key byte within the header, per length form.
    localparam logic [STEP_W-1:0] KEY_START_SHORT = STEP_W'(2);
    localparam logic [STEP_W-1:0] KEY_START_MID   = STEP_W'(4);
    localparam logic [STEP_W-1:0] KEY_START_LONG  = STEP_W'(10);
    localparam logic [STEP_W-1:0] KEY_BYTES_M1    = STEP_W'(3);

    typedef struct packed {
        logic             kind;
        logic             final_flag;
        logic [2:0]       reserved_bits;
        logic [3:0]       frame_opcode;
        logic [LEN_W-1:0] payload_length;
        logic [KEY_W-1:0] mask_word;
        logic [7:0]       data_byte;
    } req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_end;
        logic       stray_error;
    } rsp_t;

    // Classified item as it waits in the queue.
    typedef struct packed {
        logic              is_hdr;
        logic [7:0]        first_byte;
        logic [7:0]        len_byte;
        logic [STEP_W-1:0] key_start;
        logic              len_zero;
        logic [LEN_W-1:0]  length;
        logic [KEY_W-1:0]  key;
        logic [7:0]        data_byte;
    } entry_t;

    function automatic logic [7:0] key_byte(input logic [KEY_W-1:0] key,
                                            input logic [1:0]       pos);
        logic [7:0] b;
        case (pos)
            2'd0:    b = key[31:24];
            2'd1:    b = key[23:16];
            2'd2:    b = key[15:8];
            default: b = key[7:0];
        endcase
        return b;
    endfunction

endpackage

@@ src/wsfe_chan_if.sv @@
// ----------------------------------------------------------------------------
// wsfe_chan_if
// Valid/ready channel carrying one payload structure per transaction.
// ----------------------------------------------------------------------------
interface wsfe_chan_if #(
    parameter type payload_t = logic [7:0]
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/wsfe_front.sv @@
// ----------------------------------------------------------------------------
// wsfe_front
// Accepts input transactions and classifies them into queue entries.
// ----------------------------------------------------------------------------
module wsfe_front (
    wsfe_chan_if.sink         frame_req,
    input  logic              queue_full,
    output logic              push,
    output wsfe_pkg::entry_t  push_entry
);

    wsfe_pkg::req_t req;

    assign req             = frame_req.data;
    assign frame_req.ready = !queue_full;
    assign push            = frame_req.valid && !queue_full;

    always_comb
    begin
        push_entry.is_hdr     = (req.kind == wsfe_pkg::KIND_HEADER);
        push_entry.first_byte = {req.final_flag, req.reserved_bits, req.frame_opcode};
        push_entry.len_zero   = (req.payload_length == '0);
        push_entry.length     = req.payload_length;
        push_entry.key        = req.mask_word;
        push_entry.data_byte  = req.data_byte;
        if (req.payload_length <= wsfe_pkg::LEN_SHORT_MAX)
        begin
            push_entry.len_byte  = {wsfe_pkg::MASK_BIT, req.payload_length[6:0]};
            push_entry.key_start = wsfe_pkg::KEY_START_SHORT;
        end
        else if (req.payload_length <= wsfe_pkg::LEN_MID_MAX)
        begin
            push_entry.len_byte  = {wsfe_pkg::MASK_BIT, wsfe_pkg::LEN_CODE_16};
            push_entry.key_start = wsfe_pkg::KEY_START_MID;
        end
        else
        begin
            push_entry.len_byte  = {wsfe_pkg::MASK_BIT, wsfe_pkg::LEN_CODE_64};
            push_entry.key_start = wsfe_pkg::KEY_START_LONG;
        end
    end

endmodule

@@ src/wsfe_queue.sv @@
// ----------------------------------------------------------------------------
// wsfe_queue
// Short FIFO of classified entries between the front and the back.
// ----------------------------------------------------------------------------
module wsfe_queue #(
    parameter int unsigned DEPTH = wsfe_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  wsfe_pkg::entry_t push_entry,
    input  logic             pop,
    output logic             full,
    output logic             head_valid,
    output wsfe_pkg::entry_t head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    wsfe_pkg::entry_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ src/wsfe_back.sv @@
// ----------------------------------------------------------------------------
// wsfe_back
// Serializes header entries byte by byte and masks payload bytes into the
// output register.
// ----------------------------------------------------------------------------
module wsfe_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  wsfe_pkg::entry_t head,
    output logic             pop,
    wsfe_chan_if.source      frame_byte
);

    localparam int unsigned LEN_W  = wsfe_pkg::LEN_W;
    localparam int unsigned STEP_W = wsfe_pkg::STEP_W;

    logic [LEN_W-1:0]          remaining_reg, remaining_next;
    logic [1:0]                key_pos_reg, key_pos_next;
    logic [wsfe_pkg::KEY_W-1:0] key_reg, key_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic                      out_valid_reg, out_valid_next;
    wsfe_pkg::rsp_t            out_reg, out_next;

    logic              advance;
    logic              hdr_last;
    logic [STEP_W-1:0] ext_idx_full;
    logic [2:0]        ext_idx;
    logic [STEP_W-1:0] key_idx_full;
    logic [63:0]       len_wide;
    logic [63:0]       len_shift;

    assign frame_byte.valid = out_valid_reg;
    assign frame_byte.data  = out_reg;

    // The output register takes a queued byte when it is empty or being drained.
    assign advance = head_valid && (!out_valid_reg || frame_byte.ready);

    assign hdr_last     = (step_reg == head.key_start + wsfe_pkg::KEY_BYTES_M1);
    assign ext_idx_full = head.key_start - STEP_W'(1) - step_reg;
    assign ext_idx      = ext_idx_full[2:0];
    assign key_idx_full = step_reg - head.key_start;
    assign len_wide     = {1'b0, head.length};
    assign len_shift    = len_wide >> {ext_idx, 3'b000};

    always_comb
    begin
        remaining_next = remaining_reg;
        key_pos_next   = key_pos_reg;
        key_next       = key_reg;
        step_next      = step_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        pop            = 1'b0;

        if (frame_byte.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (advance)
        begin
            out_valid_next        = 1'b1;
            out_next.stray_error  = 1'b0;
            out_next.run_last     = 1'b0;
            out_next.frame_end    = 1'b0;
            if (head.is_hdr)
            begin
                if (step_reg == '0)
                begin
                    out_next.out_byte = head.first_byte;
                    // A new header replaces whatever frame was still open.
                    remaining_next    = head.length;
                    key_pos_next      = 2'd0;
                    key_next          = head.key;
                end
                else if (step_reg == STEP_W'(1))
                begin
                    out_next.out_byte = head.len_byte;
                end
                else if (step_reg < head.key_start)
                begin
                    out_next.out_byte = len_shift[7:0];
                end
                else
                begin
                    out_next.out_byte = wsfe_pkg::key_byte(head.key, key_idx_full[1:0]);
                end
                if (hdr_last)
                begin
                    out_next.run_last  = 1'b1;
                    out_next.frame_end = head.len_zero;
                    step_next          = '0;
                    pop                = 1'b1;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            else
            begin
                pop               = 1'b1;
                out_next.run_last = 1'b1;
                if (remaining_reg == '0)
                begin
                    out_next.out_byte    = 8'd0;
                    out_next.stray_error = 1'b1;
                end
                else
                begin
                    out_next.out_byte  = head.data_byte
                                         ^ wsfe_pkg::key_byte(key_reg, key_pos_reg);
                    out_next.frame_end = (remaining_reg == LEN_W'(1));
                    remaining_next     = remaining_reg - 1'b1;
                    key_pos_next       = key_pos_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= '0;
            key_pos_reg   <= '0;
            key_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            remaining_reg <= remaining_next;
            key_pos_reg   <= key_pos_next;
            key_reg       <= key_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

@@ src/websocket_client_frame_encoder.sv @@
// The first result of a transaction passes through the queue and then the output register.
// A header emits 6, 8 or 14 bytes and a payload transaction one byte, each
// byte going out through the single output byte register of the back end.
// Input transactions keep being accepted while the queue has room.
// Reset clears the queue, the frame count, the key index, the held key and the
// output valid flag.
// ----------------------------------------------------------------------------
// websocket_client_frame_encoder
// Masked client frame encoder: a front end classifies transactions into a
// short queue, and a back end serializes headers and masks payload bytes.
// ----------------------------------------------------------------------------
module websocket_client_frame_encoder #(
    parameter int unsigned QUEUE_DEPTH = wsfe_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    wsfe_chan_if.sink   frame_req,
    wsfe_chan_if.source frame_byte
);

    logic             push;
    logic             pop;
    logic             queue_full;
    logic             head_valid;
    wsfe_pkg::entry_t push_entry;
    wsfe_pkg::entry_t head;

    wsfe_front u_front (
        .frame_req  (frame_req),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    wsfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head       (head)
    );

    wsfe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .frame_byte (frame_byte)
    );

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the masked client frame encoder. Header and payload
// transactions go in through a queue-fed driver; every emitted frame byte is
// checked against a bit-accurate prediction of the framing and masking.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [wsfe_pkg::LEN_W-1:0] LEN_ALL_ONES = {wsfe_pkg::LEN_W{1'b1}};
    localparam int unsigned                LONG_HOLD    = 400;
    localparam int unsigned                HOLD_AFTER   = 300;
    localparam int unsigned                ITEM_TARGET  = 500;

    typedef struct {
        wsfe_pkg::req_t item;
        int unsigned    gap_after;
        bit             drain_first;
    } pending_t;

    logic clk;
    logic rst_n;

    wsfe_chan_if #(.payload_t(wsfe_pkg::req_t)) req_ch ();
    wsfe_chan_if #(.payload_t(wsfe_pkg::rsp_t)) byte_ch ();

    websocket_client_frame_encoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .frame_req (req_ch),
        .frame_byte(byte_ch)
    );

    pending_t         pending_items[$];
    wsfe_pkg::rsp_t   expected_bytes[$];
    int unsigned      items_accepted;
    int unsigned      results_seen;
    int unsigned      mismatch_count;
    int unsigned      src_gap;
    int unsigned      sink_stall;
    int unsigned      long_hold_left;
    bit               long_hold_done;

    // Shadow of the encoder state.
    logic [wsfe_pkg::LEN_W-1:0] frame_left;
    logic [1:0]                 key_pos;
    logic [wsfe_pkg::KEY_W-1:0] frame_key;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        rst_n         = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.data   = '0;
        byte_ch.ready = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic logic [7:0] masking_byte(input logic [wsfe_pkg::KEY_W-1:0] key,
                                                input logic [1:0]                 pos);
        return 8'(key >> (8 * (3 - int'(pos))));
    endfunction

    function automatic void expect_byte(input logic [7:0] b, input logic last,
                                        input logic fend, input logic err);
        wsfe_pkg::rsp_t e;
        e.out_byte    = b;
        e.run_last    = last;
        e.frame_end   = fend;
        e.stray_error = err;
        expected_bytes.insert(expected_bytes.size(), e);
    endfunction

    // Works out every frame byte that one accepted transaction produces.
    function automatic void predict_frame_bytes(input wsfe_pkg::req_t r);
        logic [wsfe_pkg::LEN_W-1:0] len;
        logic [63:0]                wide_len;
        logic [7:0]                 masked;
        if (r.kind == wsfe_pkg::KIND_HEADER)
        begin
            len        = r.payload_length;
            wide_len   = {1'b0, len};
            frame_key  = r.mask_word;
            key_pos    = 2'd0;
            frame_left = len;
            expect_byte({r.final_flag, r.reserved_bits, r.frame_opcode}, 1'b0, 1'b0, 1'b0);
            if (len <= wsfe_pkg::LEN_SHORT_MAX)
            begin
                expect_byte({wsfe_pkg::MASK_BIT, len[6:0]}, 1'b0, 1'b0, 1'b0);
            end
            else if (len <= wsfe_pkg::LEN_MID_MAX)
            begin
                expect_byte({wsfe_pkg::MASK_BIT, wsfe_pkg::LEN_CODE_16}, 1'b0, 1'b0, 1'b0);
                expect_byte(len[15:8], 1'b0, 1'b0, 1'b0);
                expect_byte(len[7:0], 1'b0, 1'b0, 1'b0);
            end
            else
            begin
                expect_byte({wsfe_pkg::MASK_BIT, wsfe_pkg::LEN_CODE_64}, 1'b0, 1'b0, 1'b0);
                for (int s = 7; s >= 0; s--)
                    expect_byte(8'(wide_len >> (8 * s)), 1'b0, 1'b0, 1'b0);
            end
            for (int i = 0; i < 4; i++)
                expect_byte(masking_byte(frame_key, 2'(i)), i == 3, (i == 3) && (len == '0),
                            1'b0);
        end
        else if (frame_left == '0)
        begin
            expect_byte(8'h00, 1'b1, 1'b0, 1'b1);
        end
        else
        begin
            masked     = r.data_byte ^ masking_byte(frame_key, key_pos);
            frame_left = frame_left - 1'b1;
            key_pos    = key_pos + 2'd1;
            expect_byte(masked, 1'b1, frame_left == '0, 1'b0);
        end
    endfunction

    function automatic void check_frame_byte(input wsfe_pkg::rsp_t got);
        wsfe_pkg::rsp_t want;
        if (expected_bytes.size() == 0)
        begin
            $error("frame byte %02h with no transaction pending", got.out_byte);
            mismatch_count++;
        end
        else
        begin
            want = expected_bytes.pop_front();
            if (got.out_byte !== want.out_byte)
            begin
                $error("out_byte: expected %02h, actual %02h", want.out_byte, got.out_byte);
                mismatch_count++;
            end
            if (got.run_last !== want.run_last)
            begin
                $error("run_last: expected %0b, actual %0b", want.run_last, got.run_last);
                mismatch_count++;
            end
            if (got.frame_end !== want.frame_end)
            begin
                $error("frame_end: expected %0b, actual %0b", want.frame_end, got.frame_end);
                mismatch_count++;
            end
            if (got.stray_error !== want.stray_error)
            begin
                $error("stray_error: expected %0b, actual %0b", want.stray_error,
                       got.stray_error);
                mismatch_count++;
            end
        end
    endfunction

    // Idle draws rotate through quiet, busy and sparse stretches.
    function automatic int unsigned draw_idle(input int unsigned progress);
        int unsigned mode;
        mode = (progress / 40) % 3;
        if (mode == 0)
            return $urandom_range(0, 18);
        else if (mode == 1)
            return 0;
        else
            return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
    endfunction

    function automatic wsfe_pkg::req_t header_item(input logic fin, input logic [2:0] rsv,
                                                   input logic [3:0] op,
                                                   input logic [wsfe_pkg::LEN_W-1:0] len,
                                                   input logic [wsfe_pkg::KEY_W-1:0] key);
        wsfe_pkg::req_t r;
        r.kind           = wsfe_pkg::KIND_HEADER;
        r.final_flag     = fin;
        r.reserved_bits  = rsv;
        r.frame_opcode   = op;
        r.payload_length = len;
        r.mask_word      = key;
        r.data_byte      = 8'($urandom);
        return r;
    endfunction

    // Header fields on a payload transaction are ignored, so they carry noise.
    function automatic wsfe_pkg::req_t payload_item(input logic [7:0] d);
        wsfe_pkg::req_t r;
        r.kind           = wsfe_pkg::KIND_PAYLOAD;
        r.final_flag     = 1'($urandom);
        r.reserved_bits  = 3'($urandom);
        r.frame_opcode   = 4'($urandom);
        r.payload_length = wsfe_pkg::LEN_W'({$urandom, $urandom});
        r.mask_word      = $urandom;
        r.data_byte      = d;
        return r;
    endfunction

    function automatic void queue_item(input wsfe_pkg::req_t r, input bit drain);
        pending_t p;
        p.item        = r;
        p.gap_after   = draw_idle(pending_items.size());
        p.drain_first = drain;
        pending_items.insert(pending_items.size(), p);
    endfunction

    function automatic logic [wsfe_pkg::LEN_W-1:0] long_length();
        logic [wsfe_pkg::LEN_W-1:0] l;
        l = wsfe_pkg::LEN_W'({$urandom, $urandom}) >> $urandom_range(0, 46);
        if (l <= wsfe_pkg::LEN_MID_MAX)
            l |= wsfe_pkg::LEN_W'(32'h0001_0000);
        return l;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : req_driver
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.data  <= '0;
            src_gap       = 0;
            items_accepted = 0;
            frame_left    = '0;
            key_pos       = 2'd0;
            frame_key     = '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                predict_frame_bytes(req_ch.data);
                items_accepted++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (src_gap != 0)
                begin
                    src_gap = src_gap - 1;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_items.size() != 0 &&
                         (!pending_items[0].drain_first || expected_bytes.size() == 0))
                begin
                    req_ch.valid <= 1'b1;
                    req_ch.data  <= pending_items[0].item;
                    src_gap       = pending_items[0].gap_after;
                    void'(pending_items.pop_front());
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : byte_monitor
        int unsigned wait_n;
        if (!rst_n)
        begin
            byte_ch.ready <= 1'b0;
            sink_stall     = 0;
            long_hold_left = 0;
            long_hold_done = 1'b0;
            results_seen   = 0;
        end
        else
        begin
            wait_n = sink_stall;
            if (byte_ch.valid && byte_ch.ready)
            begin
                check_frame_byte(byte_ch.data);
                results_seen++;
                wait_n = draw_idle(results_seen);
            end
            // One long back-pressure window lets the input queue fill and stall.
            if (!long_hold_done && results_seen >= HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                long_hold_left = LONG_HOLD;
            end
            if (long_hold_left != 0)
            begin
                long_hold_left = long_hold_left - 1;
                sink_stall     = wait_n;
                byte_ch.ready <= 1'b0;
            end
            else if (wait_n != 0)
            begin
                sink_stall     = wait_n - 1;
                byte_ch.ready <= 1'b0;
            end
            else
            begin
                sink_stall     = 0;
                byte_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int unsigned                sel;
        int unsigned                n_data;
        int unsigned                pending_total;
        logic [wsfe_pkg::LEN_W-1:0] len;

        mismatch_count = 0;

        // Directed: strays, empty frame, every length form at its edges,
        // key index wrap, abandoned frames and a frame that runs to its end.
        queue_item(payload_item(8'hA5), 1'b0);
        queue_item(header_item(1'b1, 3'b111, 4'hF, '0, 32'hFFFF_FFFF), 1'b0);
        queue_item(payload_item(8'h00), 1'b0);
        queue_item(header_item(1'b0, 3'b000, 4'h0, wsfe_pkg::LEN_SHORT_MAX, 32'h0000_0000),
                   1'b0);
        queue_item(payload_item(8'hFF), 1'b0);
        queue_item(header_item(1'b1, 3'b100, 4'h1, wsfe_pkg::LEN_W'(126), 32'h1234_5678),
                   1'b0);
        queue_item(payload_item(8'h00), 1'b0);
        queue_item(payload_item(8'hFF), 1'b0);
        queue_item(header_item(1'b0, 3'b010, 4'h2, wsfe_pkg::LEN_MID_MAX, 32'hA5A5_5A5A),
                   1'b0);
        queue_item(header_item(1'b1, 3'b001, 4'h8, wsfe_pkg::LEN_MID_MAX + 1'b1,
                               32'hDEAD_BEEF), 1'b0);
        queue_item(payload_item(8'h3C), 1'b0);
        queue_item(header_item(1'b1, 3'b101, 4'h9, LEN_ALL_ONES, 32'h0102_0304), 1'b0);
        queue_item(payload_item(8'hFF), 1'b0);
        queue_item(payload_item(8'h00), 1'b0);
        queue_item(payload_item(8'hAA), 1'b0);
        queue_item(payload_item(8'h55), 1'b0);
        queue_item(payload_item(8'hFF), 1'b0);
        queue_item(header_item(1'b1, 3'b000, 4'hA, wsfe_pkg::LEN_W'(3), $urandom), 1'b0);
        repeat (3) queue_item(payload_item(8'($urandom)), 1'b0);
        queue_item(payload_item(8'($urandom)), 1'b0);

        // Random frames: mostly complete short frames, plus long headers that
        // get abandoned, truncated frames and stray payload noise.
        while (pending_items.size() < ITEM_TARGET)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 65)
            begin
                len    = wsfe_pkg::LEN_W'($urandom_range(0, 10));
                n_data = int'(len);
            end
            else if (sel < 75)
            begin
                len    = wsfe_pkg::LEN_W'($urandom_range(100, 125));
                n_data = $urandom_range(0, 4);
            end
            else if (sel < 85)
            begin
                len    = wsfe_pkg::LEN_W'($urandom_range(126, 65535));
                n_data = $urandom_range(0, 4);
            end
            else if (sel < 92)
            begin
                len    = long_length();
                n_data = $urandom_range(0, 4);
            end
            else
            begin
                len    = wsfe_pkg::LEN_W'($urandom_range(2, 10));
                n_data = $urandom_range(1, int'(len) - 1);
            end
            // The first random frame waits until the directed part has drained.
            queue_item(header_item(1'($urandom), 3'($urandom), 4'($urandom), len, $urandom),
                       pending_items.size() == 22 || $urandom_range(0, 49) == 0);
            repeat (n_data) queue_item(payload_item(8'($urandom)), 1'b0);
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 2)) queue_item(payload_item(8'($urandom)), 1'b0);
        end
        pending_total = pending_items.size();

        while (items_accepted < pending_total) @(negedge clk);
        while (expected_bytes.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #(64'd20_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
